/* src/taylor_series_function_unit_macros.svh */
// Assertion macros for the Taylor-series function unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TAYLOR_SERIES_FUNCTION_UNIT_MACROS_SVH
`define TAYLOR_SERIES_FUNCTION_UNIT_MACROS_SVH

// Same-cycle implication
`define TSFU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TSFU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tsfu_pkg.sv */
// Package for the Taylor-series function unit: opcodes, widths, limits and
// the request/response structs of the shared multiply-divide unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsfu_pkg;

	localparam int T_W = 56;   // term magnitude width (capped at PCAP)
	localparam int V_W = 64;   // dividend width
	localparam int D_W = 8;    // divisor width

	localparam logic [T_W-1:0] PCAP = {T_W{1'b1}};
	localparam logic [T_W-1:0] RMAX = 56'h00_7FFF_FFFF_FFFF;

	localparam logic [2:0] OP_SIN  = 3'd0;
	localparam logic [2:0] OP_COS  = 3'd1;
	localparam logic [2:0] OP_EXP  = 3'd2;
	localparam logic [2:0] OP_SINH = 3'd3;
	localparam logic [2:0] OP_COSH = 3'd4;
	localparam logic [2:0] OP_ATAN = 3'd5;

	typedef struct packed {
		logic           start;
		logic           div_only;
		logic [D_W-1:0] d;
	} ms_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} ms_rsp_t;

endpackage
`default_nettype wire

/* src/tsfu_mulstep.sv */
// Shared multiply-divide unit: round(round(t * xm / 2^24) / d), or round(t / d) for div_only,
// capped at PCAP. One 32x32 multiplier used twice, then an 8-bit-per-cycle divider. Uses tsfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsfu_mulstep import tsfu_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ms_req_t        req,
	input  wire logic [T_W-1:0] t_in,
	input  wire logic [31:0]    xm_in,
	output ms_rsp_t             rsp,
	output logic [T_W-1:0]      q_out
);

	typedef enum logic [2:0] {
		MS_IDLE, MS_MUL_LO, MS_MUL_HI, MS_SUM, MS_DIV, MS_ROUND
	} ms_state_t;

	ms_state_t      state_q;
	logic [T_W-1:0] t_q;
	logic [31:0]    xm_q;
	logic [D_W-1:0] d_q;
	logic [V_W-1:0] prod_q;
	logic [V_W-1:0] acc_q;
	logic [V_W-1:0] num_q;
	logic [D_W-1:0] rem_q;
	logic [2:0]     cnt_q;
	logic [T_W-1:0] q_q;
	logic           done_q;
	logic           ovf_q;

	logic [31:0]    mul_a;
	logic [V_W-1:0] mul_p;
	logic [D_W-1:0] rem_n;
	logic [7:0]     qbits;
	logic           inc;
	logic [V_W:0]   qr;
	logic           cap;

	// shared multiplier: low half of t first, then high half
	always_comb begin
		mul_a = (state_q == MS_MUL_LO) ? t_q[31:0] : 32'(t_q[T_W-1:32]);
		mul_p = {32'd0, mul_a} * {32'd0, xm_q};
	end

	// eight restoring division steps per cycle
	always_comb begin
		logic [D_W:0] r9;
		rem_n = rem_q;
		qbits = '0;
		for (int i = 0; i < 8; i++) begin
			r9 = {rem_n, num_q[V_W-1-i]};
			if (r9 >= {1'b0, d_q}) begin
				r9 = r9 - {1'b0, d_q};
				qbits[7-i] = 1'b1;
			end
			rem_n = r9[D_W-1:0];
		end
	end

	// round half up, then cap
	always_comb begin
		inc = ({rem_q, 1'b0} >= {1'b0, d_q});
		qr  = {1'b0, num_q} + (V_W+1)'(inc);
		cap = (qr > (V_W+1)'(PCAP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					if (req.start) begin
						t_q   <= t_in;
						xm_q  <= xm_in;
						d_q   <= req.d;
						rem_q <= '0;
						cnt_q <= '0;
						if (req.div_only) begin
							num_q   <= V_W'(t_in);
							state_q <= MS_DIV;
						end else begin
							state_q <= MS_MUL_LO;
						end
					end
				end
				MS_MUL_LO: begin
					prod_q  <= mul_p;
					state_q <= MS_MUL_HI;
				end
				MS_MUL_HI: begin
					acc_q   <= prod_q + (V_W'(1) << 23);
					prod_q  <= mul_p;
					state_q <= MS_SUM;
				end
				MS_SUM: begin
					num_q   <= (prod_q << 8) + (acc_q >> 24);
					state_q <= MS_DIV;
				end
				MS_DIV: begin
					num_q <= {num_q[V_W-9:0], qbits};
					rem_q <= rem_n;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= MS_ROUND;
					end
				end
				MS_ROUND: begin
					q_q     <= cap ? PCAP : qr[T_W-1:0];
					ovf_q   <= cap;
					done_q  <= 1'b1;
					state_q <= MS_IDLE;
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign q_out    = q_q;

endmodule
`default_nettype wire

/* src/taylor_series_function_unit.sv */
// Taylor-series function unit, top level: APB register, term sequencer, summing.
// Depends on tsfu_pkg, tsfu_mulstep and taylor_series_function_unit_macros.svh.
//
// Usage: drive opcode (0 sin, 1 cos, 2 exp, 3 sinh, 4 cosh, 5 atan) and x_value
// (Q8.24) with start high while busy is low; that edge takes the transaction.
// busy stays high until the result is out. The result (result_value Q24.24,
// overflow, not_converged, terms_used) is shown for exactly one cycle with done
// high; the receiver cannot stall it. term_limit is written over APB at
// address 0 while the block is idle; it resets to 64.
// Every term after the first makes two passes through the shared multiply-divide
// unit for sin/cos/sinh/cosh and one for exp; atan makes two plus a divide-only
// pass, and its first term makes the divide-only pass alone. A new start is
// taken at the edge that takes the result.
// Unused opcodes answer in the cycle after start, with busy low throughout.
// Reset clears the sequencer and drops any transaction in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "taylor_series_function_unit_macros.svh"
module taylor_series_function_unit import tsfu_pkg::*; #(
	parameter int FRAC_BITS = 24,
	parameter int MAX_TERMS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [31:0] x_value,
	output logic                    done,
	output logic signed [47:0]      result_value,
	output logic                    overflow,
	output logic                    not_converged,
	output logic [6:0]              terms_used
);

	localparam int SH_L = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
	localparam int SH_R = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 1;
	localparam logic [T_W-1:0] ONE     = T_W'(1) << FRAC_BITS;
	localparam logic [T_W-1:0] RND_IN  = T_W'(1) << (SH_R - 1);
	localparam logic [6:0]     MAX_T   = 7'(MAX_TERMS);
	localparam logic signed [49:0] SUM_HI = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] SUM_LO = -50'sh0_8000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE, ST_TERM, ST_WAIT1, ST_ISSUE2, ST_WAIT2, ST_MAG, ST_WAIT_A, ST_ACC
	} st_t;

	st_t            state_q;
	logic [6:0]     term_limit_q;
	logic [6:0]     limit_q;
	logic [2:0]     op_q;
	logic           neg_q;
	logic [31:0]    xm_q;
	logic [T_W-1:0] t_q;
	logic [T_W-1:0] mag_q;
	logic [5:0]     k_q;
	logic           ovf_q;
	logic signed [47:0] sum_q;
	ms_req_t        req_q;
	ms_rsp_t        rsp;
	logic [T_W-1:0] ms_q;

	logic           done_q;
	logic [47:0]    res_q;
	logic           res_ovf_q;
	logic           res_nc_q;
	logic [6:0]     res_terms_q;

	logic           accept;
	logic           cfg_wr;
	logic [31:0]    xm_in;
	logic           neg_in;
	logic [T_W-1:0] t_init;
	logic [6:0]     limit_in;
	logic [D_W-1:0] d1;
	logic [D_W-1:0] d2;
	logic           tneg;
	logic signed [49:0] sum_n;
	logic [6:0]     k_next;

	// APB register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, term_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_limit_q <= 7'd64;
		end else if (cfg_wr && (paddr[2] == 1'b0)) begin
			term_limit_q <= pwdata[6:0];
		end
	end

	// argument magnitude, first term and clamped limit
	always_comb begin
		neg_in = x_value[31];
		xm_in  = neg_in ? (32'd0 - x_value) : x_value;
		if (FRAC_BITS >= 24) begin
			t_init = T_W'(xm_in) << SH_L;
		end else begin
			t_init = (T_W'(xm_in) + RND_IN) >> SH_R;
		end
		if (term_limit_q == 7'd0) begin
			limit_in = 7'd1;
		end else if (term_limit_q > MAX_T) begin
			limit_in = MAX_T;
		end else begin
			limit_in = term_limit_q;
		end
	end

	// divisors of the two passes for term k
	always_comb begin
		case (op_q)
			OP_SIN, OP_SINH: begin
				d1 = {1'b0, k_q, 1'b0};
				d2 = {1'b0, k_q, 1'b1};
			end
			OP_COS, OP_COSH: begin
				d1 = {1'b0, k_q, 1'b0} - 8'd1;
				d2 = {1'b0, k_q, 1'b0};
			end
			OP_EXP: begin
				d1 = {2'b0, k_q} + 8'd1;
				d2 = 8'd1;
			end
			default: begin
				d1 = 8'd1;
				d2 = 8'd1;
			end
		endcase
	end

	// term sign and running sum
	always_comb begin
		case (op_q)
			OP_SIN:  tneg = neg_q ^ k_q[0];
			OP_COS:  tneg = k_q[0];
			OP_EXP:  tneg = neg_q & ~k_q[0];
			OP_SINH: tneg = neg_q;
			OP_COSH: tneg = 1'b0;
			default: tneg = neg_q ^ k_q[0];
		endcase
		if (tneg) begin
			sum_n = 50'(sum_q) - $signed({3'b0, mag_q[46:0]});
		end else begin
			sum_n = 50'(sum_q) + $signed({3'b0, mag_q[46:0]});
		end
		k_next = {1'b0, k_q} + 7'd1;
	end

	assign accept = start && !busy;

	tsfu_mulstep u_mulstep (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.t_in   (t_q),
		.xm_in  (xm_q),
		.rsp    (rsp),
		.q_out  (ms_q)
	);

	// term sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			done_q      <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= opcode;
						neg_q   <= neg_in;
						xm_q    <= xm_in;
						limit_q <= limit_in;
						k_q     <= '0;
						ovf_q   <= 1'b0;
						t_q     <= (opcode == OP_COS || opcode == OP_COSH) ? ONE : t_init;
						sum_q   <= (opcode == OP_EXP) ? 48'(ONE) : 48'sd0;
						if (opcode > OP_ATAN) begin
							res_q       <= '0;
							res_ovf_q   <= 1'b0;
							res_nc_q    <= 1'b0;
							res_terms_q <= '0;
							done_q      <= 1'b1;
						end else begin
							state_q <= ST_TERM;
						end
					end
				end
				ST_TERM: begin
					if (k_q == 6'd0) begin
						state_q <= ST_MAG;
					end else begin
						req_q   <= '{start: 1'b1, div_only: 1'b0, d: d1};
						state_q <= ST_WAIT1;
					end
				end
				ST_WAIT1: begin
					if (rsp.done) begin
						t_q     <= ms_q;
						ovf_q   <= ovf_q | rsp.ovf;
						state_q <= (op_q == OP_EXP) ? ST_MAG : ST_ISSUE2;
					end
				end
				ST_ISSUE2: begin
					req_q   <= '{start: 1'b1, div_only: 1'b0, d: d2};
					state_q <= ST_WAIT2;
				end
				ST_WAIT2: begin
					if (rsp.done) begin
						t_q     <= ms_q;
						ovf_q   <= ovf_q | rsp.ovf;
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					if (op_q == OP_ATAN) begin
						req_q   <= '{start: 1'b1, div_only: 1'b1, d: {1'b0, k_q, 1'b1}};
						state_q <= ST_WAIT_A;
					end else begin
						mag_q   <= t_q;
						state_q <= ST_ACC;
					end
				end
				ST_WAIT_A: begin
					if (rsp.done) begin
						mag_q   <= ms_q;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					res_terms_q <= k_next;
					res_nc_q    <= 1'b0;
					res_ovf_q   <= 1'b0;
					if (ovf_q || mag_q > RMAX) begin
						// term overflow: saturate toward the term's sign
						res_q     <= tneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
						res_ovf_q <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (sum_n > SUM_HI) begin
						res_q     <= 48'h7FFF_FFFF_FFFF;
						res_ovf_q <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (sum_n < SUM_LO) begin
						res_q     <= 48'h8000_0000_0000;
						res_ovf_q <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (mag_q == '0) begin
						// converged
						res_q   <= sum_n[47:0];
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (k_next == limit_q) begin
						res_q    <= sum_n[47:0];
						res_nc_q <= 1'b1;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						sum_q   <= sum_n[47:0];
						k_q     <= k_next[5:0];
						state_q <= ST_TERM;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign result_value  = res_q;
	assign overflow      = res_ovf_q;
	assign not_converged = res_nc_q;
	assign terms_used    = res_terms_q;

	`TSFU_ASSERT_IMP(a_flags_excl, done, !(overflow && not_converged), "both flags set")
	`TSFU_ASSERT_NXT(a_accept_busy, accept, (busy || done), "accepted item dropped")
	`TSFU_ASSERT_IMP(a_nc_limit, (done && not_converged), (terms_used == limit_q), "limit mismatch")
	`TSFU_ASSERT_IMP(a_ms_idle, (rsp.done && state_q == ST_IDLE), 1'b0, "stray unit response")

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for taylor_series_function_unit: series results are
// predicted bit-exactly in fixed point and compared against the done strobe.
// Depends on tsfu_pkg and the unit RTL.
`timescale 1ns / 1ps
module tb;
	import tsfu_pkg::*;

	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam logic [63:0] TERM_CAP = 64'h00FF_FFFF_FFFF_FFFF;
	localparam int MAX_TERMS = 64;
	localparam int STALL_LIMIT = 20000;

	typedef enum {J_ITEM, J_CFG, J_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		logic [2:0]  op;
		logic [31:0] x;
		logic [6:0]  lim;
		int          idle_pct;
	} job_t;

	typedef struct {
		logic [47:0] value;
		logic        ovf;
		logic        nconv;
		logic [6:0]  terms;
	} series_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic [2:0] opcode = 0;
	logic signed [31:0] x_value = 0;
	logic done;
	logic signed [47:0] result_value;
	logic overflow, not_converged;
	logic [6:0] terms_used;

	taylor_series_function_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .opcode(opcode), .x_value(x_value),
		.done(done), .result_value(result_value), .overflow(overflow),
		.not_converged(not_converged), .terms_used(terms_used)
	);

	job_t job_q[$];
	series_res_t expected_q[$];
	logic [6:0] limit_reg = 7'd64;
	int n_acc = 0, n_res = 0, errors = 0;
	int quiet_cycles = 0;
	int hold_off = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Rounded quotient, ties up
	function automatic logic [63:0] div_rnd(input logic [63:0] v, input logic [63:0] d);
		logic [63:0] q, r;
		q = v / d;
		r = v % d;
		if (r * 2 >= d)
			q++;
		return q;
	endfunction

	// One recurrence step: round(round(t * xm / 2^24) / d), capped
	function automatic logic [63:0] term_step(input logic [63:0] t, input logic [63:0] xm,
			input logic [63:0] d, inout bit ovf);
		logic [63:0] hi, lo, lo2, v, q;
		if (t > TERM_CAP) begin
			ovf = 1;
			t = TERM_CAP;
		end
		hi = (t >> 32) * xm;
		lo = (t & 64'hFFFF_FFFF) * xm;
		lo2 = lo + (64'd1 << 23);
		v = (hi << 8) + (lo2 >> 24) + ((lo2 < lo) ? (64'd1 << 40) : 64'd0);
		q = div_rnd(v, d);
		if (q > TERM_CAP) begin
			ovf = 1;
			q = TERM_CAP;
		end
		return q;
	endfunction

	function automatic series_res_t series_eval(input logic [2:0] op, input logic [31:0] raw,
			input logic [6:0] lim_reg);
		series_res_t r;
		logic [63:0] xm, t, mag, k, limit, used;
		longint sum;
		bit neg, ovf, conv, tneg;
		neg = raw[31];
		xm = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
		limit = 64'(lim_reg);
		used = 0;
		sum = 0;
		ovf = 0;
		conv = 0;
		if (limit == 0)
			limit = 1;
		if (limit > MAX_TERMS)
			limit = MAX_TERMS;
		if (op > OP_ATAN) begin
			r = '{48'd0, 1'b0, 1'b0, 7'd0};
			return r;
		end
		t = (op == OP_COS || op == OP_COSH) ? (64'd1 << 24) : xm;
		if (op == OP_EXP)
			sum = 64'sd1 << 24;
		for (k = 0; k < limit; k++) begin
			if (k > 0) begin
				if (op == OP_SIN || op == OP_SINH) begin
					t = term_step(t, xm, 2*k, ovf);
					t = term_step(t, xm, 2*k + 1, ovf);
				end else if (op == OP_COS || op == OP_COSH) begin
					t = term_step(t, xm, 2*k - 1, ovf);
					t = term_step(t, xm, 2*k, ovf);
				end else if (op == OP_EXP) begin
					t = term_step(t, xm, k + 1, ovf);
				end else begin
					t = term_step(t, xm, 1, ovf);
					t = term_step(t, xm, 1, ovf);
				end
			end
			mag = (op == OP_ATAN) ? div_rnd(t, 2*k + 1) : t;
			case (op)
				OP_SIN, OP_ATAN: tneg = neg != k[0];
				OP_COS: tneg = k[0];
				OP_EXP: tneg = neg && !k[0];
				OP_SINH: tneg = neg;
				default: tneg = 0;
			endcase
			used = k + 1;
			if (ovf || mag > 64'(SUM_MAX)) begin
				ovf = 1;
				sum = tneg ? SUM_MIN : SUM_MAX;
				break;
			end
			if (tneg)
				sum -= longint'(mag);
			else
				sum += longint'(mag);
			if (sum > SUM_MAX) begin
				sum = SUM_MAX;
				ovf = 1;
				break;
			end
			if (sum < SUM_MIN) begin
				sum = SUM_MIN;
				ovf = 1;
				break;
			end
			if (mag == 0) begin
				conv = 1;
				break;
			end
		end
		r.value = sum[47:0];
		r.ovf = ovf;
		r.nconv = !ovf && !conv;
		r.terms = used[6:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	// Driver: issues transactions and register writes from the job queue
	always @(posedge clk or negedge arst_n) begin
		logic start_nx;
		bit idle;
		if (!arst_n) begin
			start <= 0;
			psel <= 0;
			penable <= 0;
			pwrite <= 0;
		end else begin
			start_nx = start && busy;
			idle = (n_acc == n_res) && !start && !busy;
			if (psel && penable) begin
				psel <= 0;
				penable <= 0;
				pwrite <= 0;
				hold_off <= 4;
			end else if (psel) begin
				penable <= 1;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
			end else if (!start_nx && job_q.size() > 0) begin
				case (job_q[0].kind)
					J_ITEM: begin
						if ($urandom_range(99) >= job_q[0].idle_pct) begin
							start_nx = 1;
							opcode <= job_q[0].op;
							x_value <= job_q[0].x;
							void'(job_q.pop_front());
						end
					end
					J_CFG: begin
						if (idle) begin
							psel <= 1;
							pwrite <= 1;
							paddr <= 3'd0;
							pwdata <= {25'd0, job_q[0].lim};
							void'(job_q.pop_front());
						end
					end
					default: begin
						if (idle)
							void'(job_q.pop_front());
					end
				endcase
			end
			start <= start_nx;
		end
	end

	// Monitor: predicts on acceptance, checks on the done strobe
	always @(posedge clk) begin
		series_res_t e;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				limit_reg <= pwdata[6:0];
			if (start && !busy) begin
				expected_q.push_back(series_eval(opcode, x_value, limit_reg));
				n_acc <= n_acc + 1;
			end
			if (done) begin
				n_res <= n_res + 1;
				if (expected_q.size() == 0) begin
					report_mismatch("result with no transaction outstanding");
				end else begin
					e = expected_q.pop_front();
					if (result_value !== e.value)
						report_mismatch($sformatf("result_value %h exp %h",
							result_value, e.value));
					if (overflow !== e.ovf)
						report_mismatch($sformatf("overflow %b exp %b", overflow, e.ovf));
					if (not_converged !== e.nconv)
						report_mismatch($sformatf("not_converged %b exp %b",
							not_converged, e.nconv));
					if (terms_used !== e.terms)
						report_mismatch($sformatf("terms_used %0d exp %0d",
							terms_used, e.terms));
				end
			end
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** taylor_series_function_unit: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_arg();
		int sel;
		logic [31:0] m;
		sel = $urandom_range(99);
		if (sel < 55)
			m = $urandom_range(32'h0200_0000);           // up to 2.0
		else if (sel < 75)
			m = $urandom_range(32'h0800_0000);           // up to 8.0
		else if (sel < 87)
			m = 32'h0100_0000 + $urandom_range(32'h0004_0000) - 32'h0002_0000;
		else
			return $urandom;
		return $urandom_range(1) ? -m : m;
	endfunction

	task automatic add_item(input logic [2:0] op, input logic [31:0] x, input int pct);
		job_q.push_back('{J_ITEM, op, x, 7'd0, pct});
	endtask

	task automatic add_cfg(input logic [6:0] lim);
		job_q.push_back('{J_CFG, 3'd0, 32'd0, lim, 0});
	endtask

	initial begin
		logic [31:0] dir_args[5];
		logic [6:0] limits[8];
		int pcts[8];
		logic [2:0] op;
		dir_args = '{32'h0000_0000, 32'h0100_0000, 32'hFF00_0000, 32'h7FFF_FFFF,
			32'h8000_0000};
		limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd33, 7'd64, 7'd0};
		pcts = '{0, 50, 18, 0, 50, 18, 0, 50};
		limits[7] = 7'($urandom_range(2, 100));

		// Directed: each function at zero, +-1 and the largest argument; sin also at the most negative
		for (int o = 0; o <= 5; o++)
			for (int a = 0; a < 4; a++)
				add_item(o[2:0], dir_args[a], 0);
		add_item(OP_SIN, dir_args[4], 0);
		add_item(3'd6, 32'h0123_4567, 0);
		add_item(3'd7, 32'hFFFF_FFFF, 0);

		for (int p = 0; p < 8; p++) begin
			add_cfg(limits[p]);
			for (int i = 0; i < 160; i++) begin
				op = ($urandom_range(19) == 0) ? 3'(6 + $urandom_range(1)) : 3'($urandom_range(5));
				add_item(op, rand_arg(), (i < 40) ? 0 : pcts[p]);
				if (i == 80)
					job_q.push_back('{J_DRAIN, 3'd0, 32'd0, 7'd0, 0});
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1;

		wait (job_q.size() == 0 && !start && n_acc == n_res);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("** taylor_series_function_unit: PASSED **");
		end else begin
			if (expected_q.size() != 0)
				$display("%0d results never arrived", expected_q.size());
			$display("** taylor_series_function_unit: FAILED **");
		end
		$finish;
	end

endmodule
